// ===== sv/apd_pkg.sv =====
package apd_pkg;

  localparam logic [7:0] StartByte = 8'h5A;
  localparam logic [7:0] EndByte   = 8'h0D;
  localparam logic [2:0] FirstDataPos = 3'd2;
  localparam logic [2:0] LastDataPos  = 3'd4;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned OutUserW = 2;
  localparam int unsigned AddrW    = 3;

  localparam logic [0:0] RegStationAddr = 1'b0;

  typedef enum logic {
    ReqRxByte = 1'b0,
    ReqClear  = 1'b1
  } apd_req_e;

  typedef struct packed {
    apd_req_e   req_type;
    logic [7:0] rx_byte;
  } apd_item_t;

  typedef struct packed {
    logic [7:0] level_value;
    logic [7:0] trigger_value;
    logic [7:0] output_value;
    logic [3:0] command_code;
    logic       frame_done;
    logic       packet_ready;
  } apd_result_t;

endpackage

// ===== sv/apd_in_reg.sv =====
module apd_in_reg import apd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  apd_item_t in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output apd_item_t out_item_o
);

  logic      valid_q, valid_d;
  apd_item_t item_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

// ===== sv/apd_core.sv =====
module apd_core import apd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [3:0]  station_addr_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  apd_item_t   in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output apd_result_t out_result_o
);

  logic        hunting_q, hunting_d;
  logic        loading_q, loading_d;
  logic [2:0]  pos_q, pos_d;
  logic [7:0]  store_q [4];
  logic [7:0]  store_d [4];
  logic        ready_flag_q, ready_flag_d;
  logic        done;
  logic        fire;
  logic        out_valid_q;
  apd_result_t result_q, result_d;
  logic [1:0]  store_idx;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign store_idx  = 2'(pos_q - 3'd1);

  always_comb begin
    hunting_d    = hunting_q;
    loading_d    = loading_q;
    pos_d        = pos_q;
    store_d      = store_q;
    ready_flag_d = ready_flag_q;
    done         = 1'b0;
    if (in_item_i.req_type == ReqClear) begin
      ready_flag_d = 1'b0;
    end else if (loading_q) begin
      if (pos_q >= FirstDataPos && pos_q <= LastDataPos) begin
        store_d[store_idx] = in_item_i.rx_byte;
        pos_d = pos_q + 3'd1;
      end else begin
        if (in_item_i.rx_byte == EndByte) begin
          ready_flag_d = 1'b1;
          done         = 1'b1;
        end
        loading_d = 1'b0;
        pos_d     = 3'd0;
      end
    end else if (hunting_q) begin
      if (in_item_i.rx_byte[7:4] == station_addr_i) begin
        store_d[0] = in_item_i.rx_byte;
        hunting_d  = 1'b0;
        loading_d  = 1'b1;
        pos_d      = FirstDataPos;
      end
    end else if (in_item_i.rx_byte == StartByte) begin
      hunting_d = 1'b1;
      pos_d     = 3'd0;
    end
  end

  always_comb begin
    result_d.packet_ready  = ready_flag_d;
    result_d.frame_done    = done;
    result_d.command_code  = store_d[0][3:0];
    result_d.output_value  = store_d[1];
    result_d.trigger_value = store_d[2];
    result_d.level_value   = store_d[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunting_q    <= 1'b0;
      loading_q    <= 1'b0;
      pos_q        <= 3'd0;
      ready_flag_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        store_q[i] <= 8'h00;
      end
    end else begin
      if (fire) begin
        hunting_q    <= hunting_d;
        loading_q    <= loading_d;
        pos_q        <= pos_d;
        ready_flag_q <= ready_flag_d;
        store_q      <= store_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = result_q;

endmodule

// ===== sv/addressed_packet_deframer.sv =====
// addressed packet deframer
// slave stream: one transfer per received byte (tdata) or clear request
// (tuser = 1). bytes are scanned for six-byte frames: 'Z', an address byte
// whose upper nibble equals station_address, three payload bytes and CR.
// master stream: one result transfer per input transfer, carrying the ready
// flag, a frame-done pulse and the frame fields as they stand after the byte.
// apb port: register 0 at address 0 holds station_address (4 bits).
// a transfer taken on the slave side passes the input register, then the
// result register. throughput: one transfer per cycle while the master side
// accepts, set by the state update in the core.
// when the master side stalls, both registers hold and tready falls only
// once both are full; no transfer is lost or repeated.
// reset clears the frame state, payload fields, ready flag and
// station_address; no transfers are pending after reset.
module addressed_packet_deframer import apd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // rx_byte
  input  logic                s_axis_tuser_i,   // req_type
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // command_code[3:0], output_value[11:4], trigger_value[19:12],
  // level_value[27:20], zero fill
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic [OutUserW-1:0] m_axis_tuser_o,   // packet_ready, frame_done
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [3:0]  station_q;
  logic        mid_valid, mid_ready;
  apd_item_t   in_item, mid_item;
  apd_result_t result;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_q <= 4'h0;
    end else if (psel && penable && pwrite && paddr[AddrW-1] == RegStationAddr) begin
      station_q <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[AddrW-1] == RegStationAddr) ? {28'h0, station_q} : 32'h0;

  assign in_item.req_type = apd_req_e'(s_axis_tuser_i);
  assign in_item.rx_byte  = s_axis_tdata_i;

  apd_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_item_i   (in_item),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_item_o  (mid_item)
  );

  apd_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .station_addr_i (station_q),
    .in_valid_i     (mid_valid),
    .in_ready_o     (mid_ready),
    .in_item_i      (mid_item),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_result_o   (result)
  );

  assign m_axis_tuser_o = {result.frame_done, result.packet_ready};
  assign m_axis_tdata_o = {4'h0, result.level_value, result.trigger_value,
                           result.output_value, result.command_code};

endmodule

// ===== tb/addressed_packet_deframer_tb.sv =====
module addressed_packet_deframer_tb;
  import apd_pkg::*;

  localparam int unsigned HoldCycles = 200;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned PhaseItems = 105;

  class frame_tracker;
    logic [3:0]  station_addr;
    logic        hunting;
    logic        loading;
    logic [2:0]  pos;
    logic [7:0]  store [4];
    logic        ready;
    apd_result_t pending_fields [$];

    function new();
      station_addr = 4'h0;
      hunting = 1'b0;
      loading = 1'b0;
      pos = 3'd0;
      foreach (store[i]) store[i] = 8'h00;
      ready = 1'b0;
    endfunction

    function void take_item(apd_item_t it);
      apd_result_t res;
      logic done;
      done = 1'b0;
      if (it.req_type == ReqClear) begin
        ready = 1'b0;
      end else if (loading) begin
        if (pos >= FirstDataPos && pos <= LastDataPos) begin
          store[2'(pos - 3'd1)] = it.rx_byte;
          pos = pos + 3'd1;
        end else begin
          if (it.rx_byte == EndByte) begin
            ready = 1'b1;
            done = 1'b1;
          end
          loading = 1'b0;
          pos = 3'd0;
        end
      end else if (hunting) begin
        if (it.rx_byte[7:4] == station_addr) begin
          store[0] = it.rx_byte;
          hunting = 1'b0;
          loading = 1'b1;
          pos = FirstDataPos;
        end
      end else if (it.rx_byte == StartByte) begin
        hunting = 1'b1;
        pos = 3'd0;
      end
      res.packet_ready  = ready;
      res.frame_done    = done;
      res.command_code  = store[0][3:0];
      res.output_value  = store[1];
      res.trigger_value = store[2];
      res.level_value   = store[3];
      pending_fields.push_back(res);
    endfunction

    function string compare_fields(apd_result_t got);
      apd_result_t want;
      string msg;
      msg = "";
      if (pending_fields.size() == 0) begin
        return $sformatf("result %h with none pending", got);
      end
      want = pending_fields.pop_front();
      if (got.packet_ready !== want.packet_ready)
        msg = {msg, $sformatf(" packet_ready %b/%b", got.packet_ready, want.packet_ready)};
      if (got.frame_done !== want.frame_done)
        msg = {msg, $sformatf(" frame_done %b/%b", got.frame_done, want.frame_done)};
      if (got.command_code !== want.command_code)
        msg = {msg, $sformatf(" command_code %h/%h", got.command_code, want.command_code)};
      if (got.output_value !== want.output_value)
        msg = {msg, $sformatf(" output_value %h/%h", got.output_value, want.output_value)};
      if (got.trigger_value !== want.trigger_value)
        msg = {msg, $sformatf(" trigger_value %h/%h", got.trigger_value, want.trigger_value)};
      if (got.level_value !== want.level_value)
        msg = {msg, $sformatf(" level_value %h/%h", got.level_value, want.level_value)};
      return msg;
    endfunction

    function int pending();
      return pending_fields.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = 32'h0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [OutUserW-1:0] m_axis_tuser_o;
  logic [31:0] prdata;
  logic        pready;

  frame_tracker trk = new();
  apd_item_t   byte_q [$];
  int unsigned mismatch_count = 0;
  bit          no_gaps = 1'b0;
  bit          hold_req = 1'b0;

  addressed_packet_deframer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic apd_item_t mk_item(apd_req_e r, logic [7:0] b);
    apd_item_t it;
    it.req_type = r;
    it.rx_byte = b;
    return it;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("mismatch at %0t:%s", $realtime, msg);
  endtask

  task automatic push_byte(logic [7:0] b);
    byte_q.push_back(mk_item(ReqRxByte, b));
  endtask

  task automatic push_clear();
    byte_q.push_back(mk_item(ReqClear, 8'($urandom_range(255))));
  endtask

  // start, optional stray bytes, address, payload, terminator
  task automatic push_frame(bit broken);
    logic [7:0] b;
    int unsigned sel;
    push_byte(StartByte);
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 2))
        push_byte({trk.station_addr ^ 4'($urandom_range(1, 15)), 4'($urandom_range(15))});
    end
    push_byte({trk.station_addr, 4'($urandom_range(15))});
    repeat (3) begin
      sel = $urandom_range(99);
      if (sel < 8) push_byte(StartByte);
      else if (sel < 14) push_byte(EndByte);
      else push_byte(8'($urandom_range(255)));
      if ($urandom_range(99) < 5) push_clear();
    end
    b = 8'($urandom_range(255));
    if (b == EndByte) b = b ^ 8'h01;
    push_byte(broken ? b : EndByte);
  endtask

  task automatic fill_random(int unsigned n);
    int unsigned sel;
    while (byte_q.size() < n) begin
      sel = $urandom_range(99);
      if (sel < 70) push_frame(1'b0);
      else if (sel < 80) push_byte(8'($urandom_range(255)));
      else if (sel < 90) push_clear();
      else push_frame(1'b1);
    end
  endtask

  task automatic send_items();
    apd_item_t it;
    while (byte_q.size() > 0) begin
      it = byte_q.pop_front();
      while (!no_gaps && $urandom_range(99) < 8) begin
        s_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      s_tvalid <= 1'b1;
      s_tdata <= it.rx_byte;
      s_tuser <= it.req_type;
      @(posedge clk_i);
      while (!s_axis_tready_o) @(posedge clk_i);
    end
    s_tvalid <= 1'b0;
  endtask

  // first waits for the monitor to note the last transfer, then until none is pending
  task automatic wait_drained();
    @(posedge clk_i);
    while (trk.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_station(logic [3:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {RegStationAddr, 2'b00};
    pwdata <= {28'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    trk.station_addr = v;
  endtask

  task automatic run_phase(logic [3:0] station, bit gapless, bit hold, bit pause);
    wait_drained();
    write_station(station);
    no_gaps = gapless;
    if (pause) begin
      fill_random(PhaseItems / 2);
      send_items();
      wait_drained();
    end
    fill_random(pause ? PhaseItems - PhaseItems / 2 : PhaseItems);
    if (hold) hold_req = 1'b1;
    send_items();
    no_gaps = 1'b0;
  endtask

  initial begin : sink
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_tready <= no_gaps || ($urandom_range(99) >= 8);
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    apd_result_t got;
    string msg;
    if (s_tvalid && s_axis_tready_o)
      trk.take_item(mk_item(apd_req_e'(s_tuser), s_tdata));
    if (m_axis_tvalid_o && m_tready) begin
      got.packet_ready  = m_axis_tuser_o[0];
      got.frame_done    = m_axis_tuser_o[1];
      got.command_code  = m_axis_tdata_o[3:0];
      got.output_value  = m_axis_tdata_o[11:4];
      got.trigger_value = m_axis_tdata_o[19:12];
      got.level_value   = m_axis_tdata_o[27:20];
      msg = trk.compare_fields(got);
      if (msg != "") report_mismatch(msg);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("addressed_packet_deframer test failed");
    $finish;
  end

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // station 0 from reset
    push_clear();
    push_byte(StartByte);
    push_byte(8'h0F);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(StartByte);
    push_byte(EndByte);
    push_clear();
    push_byte(StartByte);
    push_byte(8'h5A);
    push_byte(8'h13);
    push_byte(8'h00);
    push_byte(EndByte);
    push_clear();
    push_byte(EndByte);
    push_byte(8'h00);
    send_items();
    wait_drained();

    // start byte taken as the address byte
    write_station(4'h5);
    push_byte(StartByte);
    push_byte(StartByte);
    push_byte(8'h80);
    push_byte(8'h7F);
    push_byte(8'h01);
    push_byte(EndByte);
    send_items();

    run_phase(4'hF, 1'b0, 1'b0, 1'b0);
    run_phase(4'h0, 1'b1, 1'b0, 1'b0);
    run_phase(4'($urandom_range(15)), 1'b0, 1'b1, 1'b0);
    run_phase(4'($urandom_range(15)), 1'b0, 1'b0, 1'b1);
    run_phase(4'h5, 1'b0, 1'b0, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && trk.pending() == 0) begin
      $display("addressed_packet_deframer test passed");
    end else begin
      $display("addressed_packet_deframer test failed");
    end
    $finish;
  end

endmodule

// ===== addressed_packet_deframer.f =====
sv/apd_pkg.sv
sv/apd_in_reg.sv
sv/apd_core.sv
sv/addressed_packet_deframer.sv
tb/addressed_packet_deframer_tb.sv
